// ===== rtl/tcp_hp_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP header parser package
// Shared record types, queue sizing and protocol constants.
// ----------------------------------------------------------------------------
package tcp_hp_pkg;

  // record kinds (out_tuser)
  localparam logic [1:0] REC_OPTION = 2'd0;
  localparam logic [1:0] REC_HEADER = 2'd1;
  localparam logic [1:0] REC_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SHORT  = 2'd1;  // fewer than 20 bytes
  localparam logic [1:0] ERR_OFFSET = 2'd2;  // data offset below 5 words
  localparam logic [1:0] ERR_TRUNC  = 2'd3;  // segment shorter than header

  // option kinds
  localparam logic [7:0] OPT_EOL    = 8'd0;
  localparam logic [7:0] OPT_NOP    = 8'd1;
  localparam logic [7:0] OPT_MSS    = 8'd2;
  localparam logic [7:0] OPT_WSCALE = 8'd3;
  localparam logic [7:0] OPT_SACKP  = 8'd4;
  localparam logic [7:0] OPT_TSTAMP = 8'd8;

  localparam logic [7:0] LEN_MSS    = 8'd4;
  localparam logic [7:0] LEN_WSCALE = 8'd3;
  localparam logic [7:0] LEN_TSTAMP = 8'd10;
  localparam logic [7:0] LEN_MIN    = 8'd2;

  // header geometry
  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned HDR_BITS   = HDR_BYTES * 8;
  localparam logic [5:0]  HDR_MIN    = 6'd20;
  localparam logic [5:0]  IDX_MAX    = 6'd63;
  localparam logic [3:0]  MIN_WORDS  = 4'd5;

  // queue sizing
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned TDATA_W = 168;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [5:0]  len;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] check;
    logic [15:0] urgent;
    logic [7:0]  opt_code;
  } rec_t;

  // everything one input word produces: an option record, a final record, or both
  typedef struct packed {
    logic opt_v;
    rec_t opt;
    logic fin_v;
    rec_t fin;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } head_t;

endpackage

// ===== rtl/tcp_header_parser.sv =====
// ----------------------------------------------------------------------------
// TCP header parser
// Byte-stream TCP header and option parser emitting option, header and
// error records.
// ----------------------------------------------------------------------------
// The records of a byte are written to the queue when the byte is accepted and
//   then loaded into the output register; an output stall can delay that load.
// Input: one byte per cycle while the queue has room; a byte that ends an option
//   and the segment together yields two records, sent as two output words; the
//   4-entry queue between parser and output stage absorbs that.
// Reset (synchronous, rst_n low): parser idle, queue empty, no output valid.
// ----------------------------------------------------------------------------
module tcp_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  // byte input
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tuser,    // [0] seg_start
  input  logic         in_tlast,    // seg_end
  // record output
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] error_code, [17:2] source port, [33:18] destination port,
  // [65:34] word_a, [97:66] word_b, [103:98] length_bytes,
  // [111:104] flag byte, [127:112] window_size, [143:128] check_value,
  // [159:144] urgent_ptr, [167:160] option_kind
  output logic [167:0] out_tdata,
  output logic [1:0]   out_tuser    // [1:0] record_kind
);

  tcp_hp_pkg::push_t push;
  tcp_hp_pkg::head_t head;
  logic              q_room;
  logic              pop;

  // front: byte counting, header capture, option walk
  tcp_hp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_room    (q_room),
    .push      (push)
  );

  // decouples the parser from output backpressure
  tcp_hp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (q_room),
    .head  (head),
    .pop   (pop)
  );

  // back: one record per output word
  tcp_hp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // records are only produced by an accepted byte
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (in_tvalid && in_tready))
    else $error("record entry pushed without an accepted byte");

  // header records never carry an error code
  a_header_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == tcp_hp_pkg::REC_HEADER) |->
      (out_tdata[1:0] == tcp_hp_pkg::ERR_NONE))
    else $error("header record with error code");

  // option records have a legal length and no error code
  a_option_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == tcp_hp_pkg::REC_OPTION) |->
      (out_tdata[103:98] >= 6'd2 && out_tdata[1:0] == tcp_hp_pkg::ERR_NONE))
    else $error("malformed option record");

  // only option records name an option kind
  a_kind_only_opt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != tcp_hp_pkg::REC_OPTION) |->
      (out_tdata[167:160] == 8'd0))
    else $error("option kind on a final record");

endmodule

// ===== rtl/tcp_hp_front.sv =====
// ----------------------------------------------------------------------------
// TCP header parser front end
// Counts segment bytes, captures the fixed header, walks the options and
// builds the records for each accepted word.
// ----------------------------------------------------------------------------
module tcp_hp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tuser,   // [0] seg_start
  input  logic               in_tlast,   // seg_end
  input  logic               q_room,
  output tcp_hp_pkg::push_t  push
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_KIND = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [5:0]                      idx_r, idx_nxt;
  logic                            stop_r, stop_nxt;
  logic [5:0]                      noff_r, noff_nxt;
  logic [7:0]                      okind_r, okind_nxt;
  logic [7:0]                      olen_r, olen_nxt;
  logic [63:0]                     acc_r, acc_nxt;
  logic [tcp_hp_pkg::HDR_BITS-1:0] hdr_r, hdr_nxt;

  logic accept;
  assign in_tready = q_room;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_t      ph;
    logic [5:0]  i;
    logic [5:0]  hl;
    logic [3:0]  hw;
    logic [5:0]  start;
    logic [8:0]  span;
    logic        opt_done;
    logic        opt_ok;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [7:0]  b;

    b         = in_tdata;
    ph        = phase_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    stop_nxt  = stop_r;
    noff_nxt  = noff_r;
    okind_nxt = okind_r;
    olen_nxt  = olen_r;
    acc_nxt   = acc_r;
    hdr_nxt   = hdr_r;
    opt_done  = 1'b0;
    opt_ok    = 1'b0;
    wa        = '0;
    wb        = '0;
    hw        = '0;
    i         = '0;
    start     = '0;
    span      = '0;
    hl        = {hdr_r[63:60], 2'b00};  // data offset nibble of byte 12
    push      = '0;

    if (accept) begin
      if (in_tuser) begin
        ph        = PH_KIND;
        phase_nxt = PH_KIND;
        idx_nxt   = '0;
        stop_nxt  = 1'b0;
        noff_nxt  = tcp_hp_pkg::HDR_MIN;
        okind_nxt = '0;
        olen_nxt  = '0;
        acc_nxt   = '0;
      end

      if (ph != PH_IDLE) begin
        i = idx_nxt;
        if (i < tcp_hp_pkg::IDX_MAX) idx_nxt = i + 6'd1;
        if (i < tcp_hp_pkg::HDR_MIN) hdr_nxt = {hdr_r[tcp_hp_pkg::HDR_BITS-9:0], b};

        // option walk over bytes 20 .. header length - 1
        if (i >= tcp_hp_pkg::HDR_MIN && i < hl && !stop_nxt) begin
          case (ph)
            PH_KIND: begin
              if (b == tcp_hp_pkg::OPT_EOL) begin
                stop_nxt = 1'b1;
              end else if (b == tcp_hp_pkg::OPT_NOP) begin
                stop_nxt = stop_nxt;
              end else if ({1'b0, i} + 7'd1 >= {1'b0, hl}) begin
                stop_nxt = 1'b1;  // no room for a length byte
              end else begin
                okind_nxt = b;
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              start     = i - 6'd1;
              span      = {3'b000, start} + {1'b0, b};
              phase_nxt = PH_KIND;
              if (b < tcp_hp_pkg::LEN_MIN || span > {3'b000, hl}) begin
                stop_nxt = 1'b1;
              end else begin
                olen_nxt = b;
                acc_nxt  = '0;
                noff_nxt = span[5:0];
                if (b == tcp_hp_pkg::LEN_MIN) opt_done = 1'b1;
                else phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              acc_nxt = {acc_r[55:0], b};
              if ({1'b0, i} + 7'd1 == {1'b0, noff_r}) begin
                opt_done  = 1'b1;
                phase_nxt = PH_KIND;
              end
            end
            default: phase_nxt = ph;
          endcase
        end

        // option record check on the completed option
        if (opt_done) begin
          opt_ok = 1'b1;
          case (okind_nxt)
            tcp_hp_pkg::OPT_MSS: begin
              if (olen_nxt != tcp_hp_pkg::LEN_MSS) opt_ok = 1'b0;
              wa = {16'h0000, acc_nxt[15:0]};
            end
            tcp_hp_pkg::OPT_WSCALE: begin
              if (olen_nxt != tcp_hp_pkg::LEN_WSCALE) opt_ok = 1'b0;
              wa = {24'h000000, acc_nxt[7:0]};
            end
            tcp_hp_pkg::OPT_SACKP: opt_ok = 1'b1;
            tcp_hp_pkg::OPT_TSTAMP: begin
              if (olen_nxt != tcp_hp_pkg::LEN_TSTAMP) opt_ok = 1'b0;
              wa = acc_nxt[63:32];
              wb = acc_nxt[31:0];
            end
            default: opt_ok = 1'b1;
          endcase
        end
        push.ent.opt_v        = opt_ok;
        push.ent.opt.kind     = tcp_hp_pkg::REC_OPTION;
        push.ent.opt.err      = tcp_hp_pkg::ERR_NONE;
        push.ent.opt.word_a   = wa;
        push.ent.opt.word_b   = wb;
        push.ent.opt.len      = olen_nxt[5:0];
        push.ent.opt.opt_code = okind_nxt;

        // closing record on the segment's last byte
        if (in_tlast) begin
          hw        = hdr_nxt[63:60];
          phase_nxt = PH_IDLE;
          push.ent.fin_v = 1'b1;
          if (idx_nxt < tcp_hp_pkg::HDR_MIN) begin
            push.ent.fin.kind = tcp_hp_pkg::REC_ERROR;
            push.ent.fin.err  = tcp_hp_pkg::ERR_SHORT;
          end else begin
            push.ent.fin.sport = hdr_nxt[159:144];
            push.ent.fin.dport = hdr_nxt[143:128];
            push.ent.fin.len   = {hw, 2'b00};
            push.ent.fin.flags = hdr_nxt[55:48];
            if (hw < tcp_hp_pkg::MIN_WORDS) begin
              push.ent.fin.kind = tcp_hp_pkg::REC_ERROR;
              push.ent.fin.err  = tcp_hp_pkg::ERR_OFFSET;
            end else if (idx_nxt < {hw, 2'b00}) begin
              push.ent.fin.kind = tcp_hp_pkg::REC_ERROR;
              push.ent.fin.err  = tcp_hp_pkg::ERR_TRUNC;
            end else begin
              push.ent.fin.kind   = tcp_hp_pkg::REC_HEADER;
              push.ent.fin.err    = tcp_hp_pkg::ERR_NONE;
              push.ent.fin.word_a = hdr_nxt[127:96];
              push.ent.fin.word_b = hdr_nxt[95:64];
              push.ent.fin.window = hdr_nxt[47:32];
              push.ent.fin.check  = hdr_nxt[31:16];
              push.ent.fin.urgent = hdr_nxt[15:0];
            end
          end
        end
        push.valid = push.ent.opt_v || push.ent.fin_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      stop_r  <= 1'b0;
      noff_r  <= tcp_hp_pkg::HDR_MIN;
      okind_r <= '0;
      olen_r  <= '0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      stop_r  <= stop_nxt;
      noff_r  <= noff_nxt;
      okind_r <= okind_nxt;
      olen_r  <= olen_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // header bytes are always fully rewritten before use
  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

// ===== rtl/tcp_hp_queue.sv =====
// ----------------------------------------------------------------------------
// TCP header parser queue
// Small register FIFO of per-word record entries between front and back.
// ----------------------------------------------------------------------------
module tcp_hp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tcp_hp_pkg::push_t  push,
  output logic               room,
  output tcp_hp_pkg::head_t  head,
  input  logic               pop
);

  tcp_hp_pkg::entry_t                mem_r [tcp_hp_pkg::QDEPTH];
  logic [tcp_hp_pkg::QPTR_W-1:0]     wp_r, wp_nxt;
  logic [tcp_hp_pkg::QPTR_W-1:0]     rp_r, rp_nxt;
  logic [tcp_hp_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign room       = cnt_r != tcp_hp_pkg::QCNT_W'(tcp_hp_pkg::QDEPTH);
  assign head.valid = cnt_r != '0;
  assign head.ent   = mem_r[rp_r];
  assign do_push    = push.valid && room;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push.ent;
  end

endmodule

// ===== rtl/tcp_hp_back.sv =====
// ----------------------------------------------------------------------------
// TCP header parser back end
// Splits queue entries into single records and drives the output register.
// ----------------------------------------------------------------------------
module tcp_hp_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcp_hp_pkg::head_t                head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcp_hp_pkg::TDATA_W-1:0]   out_tdata,
  output logic [1:0]                       out_tuser
);

  logic               vld_r, vld_nxt;
  logic               pend_r, pend_nxt;
  tcp_hp_pkg::rec_t   rec_r, rec_nxt;
  tcp_hp_pkg::rec_t   prec_r, prec_nxt;
  logic               free;

  assign free = !vld_r || out_tready;

  always_comb begin
    pop      = 1'b0;
    vld_nxt  = vld_r;
    pend_nxt = pend_r;
    rec_nxt  = rec_r;
    prec_nxt = prec_r;
    if (free) begin
      if (pend_r) begin
        // final record held back behind an option record
        rec_nxt  = prec_r;
        vld_nxt  = 1'b1;
        pend_nxt = 1'b0;
      end else if (head.valid) begin
        pop     = 1'b1;
        vld_nxt = 1'b1;
        if (head.ent.opt_v) begin
          rec_nxt  = head.ent.opt;
          pend_nxt = head.ent.fin_v;
          prec_nxt = head.ent.fin;
        end else begin
          rec_nxt = head.ent.fin;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    prec_r <= prec_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = rec_r.kind;
  assign out_tdata  = {rec_r.opt_code, rec_r.urgent, rec_r.check, rec_r.window,
                       rec_r.flags, rec_r.len, rec_r.word_b, rec_r.word_a,
                       rec_r.dport, rec_r.sport, rec_r.err};

endmodule

// ===== sim/tcp_header_parser_chk.sv =====
// ----------------------------------------------------------------------------
// TCP header parser checker
// Watches both stream channels, predicts the records of every accepted byte
// word and compares each returned record field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_header_parser_chk (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           pending,
  output int           fail_count
);

  typedef enum logic [1:0] {WALK_IDLE, WALK_KIND, WALK_LEN, WALK_DATA} walk_t;

  // shadow of the parser state
  walk_t       walk;
  logic [5:0]  idx;
  logic [3:0]  hwords;
  logic [63:0] hreg [3];
  logic [5:0]  opt_end;
  logic [7:0]  okind;
  logic [7:0]  olen;
  logic [63:0] oacc;
  logic        ostop;

  tcp_hp_pkg::rec_t records_due [$];

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic new_segment();
    idx     = '0;
    hwords  = '0;
    hreg[0] = '0;
    hreg[1] = '0;
    hreg[2] = '0;
    opt_end = tcp_hp_pkg::HDR_MIN;
    okind   = '0;
    olen    = '0;
    oacc    = '0;
    ostop   = 1'b0;
  endtask

  // completed option: record for every kind but MSS, window scale or timestamp at a wrong length
  task automatic push_option();
    tcp_hp_pkg::rec_t r;
    logic ok;
    r          = '0;
    ok         = 1'b1;
    r.kind     = tcp_hp_pkg::REC_OPTION;
    r.len      = olen[5:0];
    r.opt_code = okind;
    case (okind)
      tcp_hp_pkg::OPT_MSS: begin
        ok       = (olen == tcp_hp_pkg::LEN_MSS);
        r.word_a = {16'd0, oacc[15:0]};
      end
      tcp_hp_pkg::OPT_WSCALE: begin
        ok       = (olen == tcp_hp_pkg::LEN_WSCALE);
        r.word_a = {24'd0, oacc[7:0]};
      end
      tcp_hp_pkg::OPT_TSTAMP: begin
        ok       = (olen == tcp_hp_pkg::LEN_TSTAMP);
        r.word_a = oacc[63:32];
        r.word_b = oacc[31:0];
      end
      default: ;
    endcase
    if (ok) records_due.push_back(r);
  endtask

  task automatic predict_records(input logic [7:0] b, input logic st, input logic en);
    int   i;
    int   hl;
    int   start;
    tcp_hp_pkg::rec_t r;
    if (st) begin
      new_segment();
      walk = WALK_KIND;
    end
    if (walk != WALK_IDLE) begin
      i = idx;
      if (idx != tcp_hp_pkg::IDX_MAX) idx = idx + 6'd1;
      if (i < tcp_hp_pkg::HDR_MIN) begin
        hreg[i / 8] = {hreg[i / 8][55:0], b};
        if (i == 12) hwords = b[7:4];
      end
      hl = hwords * 4;
      if (i >= tcp_hp_pkg::HDR_MIN && i < hl && !ostop) begin
        case (walk)
          WALK_KIND: begin
            if (b == tcp_hp_pkg::OPT_EOL) ostop = 1'b1;
            else if (b == tcp_hp_pkg::OPT_NOP) ;
            else if (i + 1 >= hl) ostop = 1'b1;   // no room for a length
            else begin
              okind = b;
              walk  = WALK_LEN;
            end
          end
          WALK_LEN: begin
            start = i - 1;
            walk  = WALK_KIND;
            if (b < tcp_hp_pkg::LEN_MIN || start + b > hl) ostop = 1'b1;
            else begin
              olen    = b;
              oacc    = '0;
              opt_end = 6'(start + b);
              if (b == tcp_hp_pkg::LEN_MIN) push_option();
              else walk = WALK_DATA;
            end
          end
          default: begin
            oacc = {oacc[55:0], b};
            if (i + 1 == opt_end) begin
              push_option();
              walk = WALK_KIND;
            end
          end
        endcase
      end
      if (en) begin
        r = '0;
        if (idx < tcp_hp_pkg::HDR_MIN) begin
          r.kind = tcp_hp_pkg::REC_ERROR;
          r.err  = tcp_hp_pkg::ERR_SHORT;
        end else begin
          r.sport = hreg[0][63:48];
          r.dport = hreg[0][47:32];
          r.flags = hreg[1][23:16];
          r.len   = 6'(hl);
          if (hwords < tcp_hp_pkg::MIN_WORDS) begin
            r.kind = tcp_hp_pkg::REC_ERROR;
            r.err  = tcp_hp_pkg::ERR_OFFSET;
          end else if (idx < hl) begin
            r.kind = tcp_hp_pkg::REC_ERROR;
            r.err  = tcp_hp_pkg::ERR_TRUNC;
          end else begin
            r.kind   = tcp_hp_pkg::REC_HEADER;
            r.word_a = hreg[0][31:0];
            r.word_b = hreg[1][63:32];
            r.window = hreg[1][15:0];
            r.check  = hreg[2][31:16];
            r.urgent = hreg[2][15:0];
          end
        end
        records_due.push_back(r);
        walk = WALK_IDLE;
      end
    end
  endtask

  always @(posedge clk) begin
    tcp_hp_pkg::rec_t got;
    tcp_hp_pkg::rec_t want;
    if (!rst_n) begin
      records_due.delete();
      new_segment();
      walk = WALK_IDLE;
    end else begin
      if (in_tvalid && in_tready) predict_records(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        got.kind     = out_tuser;
        got.err      = out_tdata[1:0];
        got.sport    = out_tdata[17:2];
        got.dport    = out_tdata[33:18];
        got.word_a   = out_tdata[65:34];
        got.word_b   = out_tdata[97:66];
        got.len      = out_tdata[103:98];
        got.flags    = out_tdata[111:104];
        got.window   = out_tdata[127:112];
        got.check    = out_tdata[143:128];
        got.urgent   = out_tdata[159:144];
        got.opt_code = out_tdata[167:160];
        if (records_due.size() == 0) begin
          report($sformatf("record with nothing due, kind %0d", got.kind));
        end else begin
          want = records_due.pop_front();
          cmp_field("record_kind",  got.kind,     want.kind);
          cmp_field("error_code",   got.err,      want.err);
          cmp_field("source_port",  got.sport,    want.sport);
          cmp_field("dest_port",    got.dport,    want.dport);
          cmp_field("word_a",       got.word_a,   want.word_a);
          cmp_field("word_b",       got.word_b,   want.word_b);
          cmp_field("length_bytes", got.len,      want.len);
          cmp_field("flag_byte",    got.flags,    want.flags);
          cmp_field("window_size",  got.window,   want.window);
          cmp_field("check_value",  got.check,    want.check);
          cmp_field("urgent_ptr",   got.urgent,   want.urgent);
          cmp_field("option_kind",  got.opt_code, want.opt_code);
        end
      end
    end
    pending <= records_due.size();
  end

endmodule

// ===== sim/tcp_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// TCP header parser testbench
// Feeds byte segments (directed corner cases, then random well-formed and
// broken headers with option lists) under bursty input and a stalling
// receiver; the checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_header_parser_tb;

  localparam int SEG_BYTES = 1300;  // segment byte words to send over the run
  localparam int WATCHDOG  = 5000;  // cycles with no word moving on either side
  localparam int DRAIN     = 16;    // settle time after the last record

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;
  logic         in_tuser   = 1'b0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic [1:0]   out_tuser;

  int pending;       // records predicted but not yet seen
  int fail_count;

  // segment under construction, one byte per entry in wire order
  logic [7:0] seg_q [$];
  int         sent       = 0;
  int         burst_left = 0;
  int         stall_cycles = 0;

  // receiver stall pattern
  logic [1:0] rx_mode = 2'd0;
  int         rx_left = 0;

  logic [7:0] known_kinds [4] = '{tcp_hp_pkg::OPT_MSS, tcp_hp_pkg::OPT_WSCALE,
                                  tcp_hp_pkg::OPT_SACKP, tcp_hp_pkg::OPT_TSTAMP};

  tcp_header_parser uut (.*);

  tcp_header_parser_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: switches between always ready, mostly ready, mostly stalled and
  // a fixed 5-of-8 duty pattern, each held for a random stretch.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_left[2:0] > 3'd2);
    endcase
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  // One byte word. The sender runs in bursts; between bursts tvalid drops for
  // a random gap. Roughly one burst in eight is long, giving gap-free runs.
  task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    in_tlast  <= en;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Sends the first n bytes of seg_q; seg_start on the first, seg_end on the
  // last only when asked (a prefix without end is later cut by a restart).
  task automatic send_seg(input int n, input logic with_end);
    for (int k = 0; k < n; k++) begin
      send_byte(seg_q[k], k == 0, with_end && (k == n - 1));
      sent++;
    end
  endtask

  // Starts a new segment with a 20-byte fixed header. fill < 0 gives random
  // fields, otherwise every byte is fill; the data offset nibble is forced.
  task automatic put_hdr(input logic [3:0] doff, input int fill);
    seg_q.delete();
    for (int k = 0; k < 20; k++)
      seg_q.push_back((fill < 0) ? rnd_byte() : 8'(fill));
    seg_q[12] = {doff, seg_q[12][3:0]};
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random segment: mostly legal headers with a mixed option list, plus bad
  // offsets, malformed/overrunning options and stray EOL tails.
  task automatic build_random_segment();
    logic [3:0] doff;
    int         target;
    int         len;
    int         n;
    case ($urandom_range(0, 9))
      0:             doff = 4'($urandom_range(0, 4));
      1, 2, 3, 4, 5: doff = 4'($urandom_range(5, 8));
      default:       doff = 4'($urandom_range(9, 15));
    endcase
    put_hdr(doff, -1);
    target = (doff >= tcp_hp_pkg::MIN_WORDS) ? doff * 4 : 20;
    while (seg_q.size() < target) begin
      case ($urandom_range(0, 15))
        0, 1: seg_q.push_back(tcp_hp_pkg::OPT_NOP);
        2, 3: seg_q = {seg_q, tcp_hp_pkg::OPT_MSS, tcp_hp_pkg::LEN_MSS,
                       rnd_byte(), rnd_byte()};
        4:    seg_q = {seg_q, tcp_hp_pkg::OPT_WSCALE, tcp_hp_pkg::LEN_WSCALE,
                       rnd_byte()};
        5:    seg_q = {seg_q, tcp_hp_pkg::OPT_SACKP, tcp_hp_pkg::LEN_MIN};
        6, 7: begin
          seg_q = {seg_q, tcp_hp_pkg::OPT_TSTAMP, tcp_hp_pkg::LEN_TSTAMP};
          repeat (8) seg_q.push_back(rnd_byte());
        end
        8: begin  // kind 5 to 255, mostly unknown, length 2 to 12
          len   = $urandom_range(2, 12);
          seg_q = {seg_q, 8'($urandom_range(5, 255)), 8'(len)};
          repeat (len - 2) seg_q.push_back(rnd_byte());
        end
        9: begin  // known kind, length usually wrong
          len   = $urandom_range(2, 12);
          seg_q = {seg_q, known_kinds[$urandom_range(0, 3)], 8'(len)};
          repeat (len - 2) seg_q.push_back(rnd_byte());
        end
        10: begin  // end of list, garbage after it
          seg_q.push_back(tcp_hp_pkg::OPT_EOL);
          while (seg_q.size() < target) seg_q.push_back(rnd_byte());
        end
        11: seg_q = {seg_q, 8'($urandom_range(2, 255)), 8'($urandom_range(0, 1))};
        12: begin  // option claims to run past the header
          len   = target - seg_q.size() + $urandom_range(1, 6);
          seg_q = {seg_q, 8'($urandom_range(2, 255)), 8'(len)};
        end
        default: seg_q.push_back(rnd_byte());
      endcase
    end
    while (seg_q.size() > target) void'(seg_q.pop_back());
    // payload: short usually, now and then long enough to pin the byte count
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 4);
    repeat (n) seg_q.push_back(rnd_byte());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // start and end on the same byte
    seg_q = {rnd_byte()};
    send_seg(1, 1'b1);
    // stray byte outside a segment, then a segment one byte short
    send_byte(8'h3C, 1'b0, 1'b1);
    put_hdr(4'd5, -1);
    send_seg(19, 1'b1);
    // all-ones fields, minimal header
    put_hdr(4'd5, 8'hFF);
    send_seg(seg_q.size(), 1'b1);
    // all-zero header: data offset 0
    put_hdr(4'd0, 8'h00);
    send_seg(seg_q.size(), 1'b1);
    // full 60-byte header with every option kind, then EOL and junk
    put_hdr(4'd15, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_MSS, tcp_hp_pkg::LEN_MSS, 8'hFF, 8'hFF,
             tcp_hp_pkg::OPT_WSCALE, tcp_hp_pkg::LEN_WSCALE, 8'h0E,
             tcp_hp_pkg::OPT_SACKP, tcp_hp_pkg::LEN_MIN,
             tcp_hp_pkg::OPT_TSTAMP, tcp_hp_pkg::LEN_TSTAMP,
             8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
             tcp_hp_pkg::OPT_NOP, 8'd30, 8'd4, 8'hAA, 8'h55, tcp_hp_pkg::OPT_EOL};
    while (seg_q.size() < 62) seg_q.push_back(rnd_byte());
    send_seg(seg_q.size(), 1'b1);
    // option emitted, then segment ends inside the header
    put_hdr(4'd8, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_MSS, tcp_hp_pkg::LEN_MSS, 8'h05, 8'hB4,
             tcp_hp_pkg::OPT_NOP};
    send_seg(seg_q.size(), 1'b1);
    // option and header record from the same last byte
    put_hdr(4'd6, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_MSS, tcp_hp_pkg::LEN_MSS, 8'h05, 8'hB4};
    send_seg(seg_q.size(), 1'b1);
    // wrong-length MSS skipped, window scale still reported
    put_hdr(4'd7, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_MSS, 8'd3, 8'h11, tcp_hp_pkg::OPT_WSCALE,
             tcp_hp_pkg::LEN_WSCALE, 8'd7, tcp_hp_pkg::OPT_NOP, tcp_hp_pkg::OPT_NOP};
    send_seg(seg_q.size(), 1'b1);
    // wrong-length timestamp, SACK-permitted at length 4
    put_hdr(4'd8, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_TSTAMP, 8'd6, 8'h01, 8'h02, 8'h03, 8'h04,
             tcp_hp_pkg::OPT_SACKP, 8'd4, 8'hDE, 8'hAD,
             tcp_hp_pkg::OPT_NOP, tcp_hp_pkg::OPT_NOP};
    send_seg(seg_q.size(), 1'b1);
    // length below 2 stops the walk
    put_hdr(4'd6, -1);
    seg_q = {seg_q, 8'd5, 8'd1, tcp_hp_pkg::OPT_MSS, tcp_hp_pkg::LEN_MSS};
    send_seg(seg_q.size(), 1'b1);
    // option running past the header
    put_hdr(4'd6, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_TSTAMP, tcp_hp_pkg::LEN_TSTAMP, 8'h12, 8'h34};
    send_seg(seg_q.size(), 1'b1);
    // kind on the last header byte, no room for a length
    put_hdr(4'd6, -1);
    seg_q = {seg_q, tcp_hp_pkg::OPT_NOP, tcp_hp_pkg::OPT_NOP, tcp_hp_pkg::OPT_NOP,
             8'd30};
    send_seg(seg_q.size(), 1'b1);
    // restart mid-segment drops the first one silently
    put_hdr(4'd5, -1);
    send_seg(10, 1'b0);
    put_hdr(4'd5, -1);
    send_seg(seg_q.size(), 1'b1);
    // long payload, byte count saturates
    put_hdr(4'd5, -1);
    repeat (50) seg_q.push_back(rnd_byte());
    send_seg(seg_q.size(), 1'b1);
    pause_until_drained();

    // ---- random ----
    while (sent < SEG_BYTES) begin
      case ($urandom_range(0, 19))
        0: repeat ($urandom_range(1, 3))   // ignored while idle
             send_byte(rnd_byte(), 1'b0, 1'($urandom_range(0, 1)));
        1: begin
          build_random_segment();
          send_seg($urandom_range(1, seg_q.size() - 1), 1'b0);
          build_random_segment();
          send_seg(seg_q.size(), 1'b1);
        end
        2: begin
          seg_q = {rnd_byte()};
          send_seg(1, 1'b1);
        end
        3: pause_until_drained();
        default: begin
          build_random_segment();
          // occasionally cut short anywhere
          send_seg(($urandom_range(0, 7) == 0) ? $urandom_range(1, seg_q.size())
                                               : seg_q.size(), 1'b1);
        end
      endcase
    end

    pause_until_drained();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== tcp_header_parser.f =====
rtl/tcp_hp_pkg.sv
rtl/tcp_hp_front.sv
rtl/tcp_hp_queue.sv
rtl/tcp_hp_back.sv
rtl/tcp_header_parser.sv
sim/tcp_header_parser_chk.sv
sim/tcp_header_parser_tb.sv
